@@ rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SHP_ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("assertion failed");
`else
`define SHP_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define SHP_ASSERT_NEVER(label, clk, rst_n, a)
`endif
`endif

@@ rtl/shp_pkg.sv @@
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants of the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
`default_nettype none
package shp_pkg;
    localparam int CHANNEL_BITS   = 8;
    localparam int NUM_CH         = 3;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int ROW_BITS       = 13;
    localparam int ROW_SAT        = 8191;
    localparam int AMT_BITS       = 12;
    localparam int FW_BITS        = 11;
    localparam int FH_BITS        = 13;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int SUM_BITS       = 10;
    localparam int CNT_BITS       = 3;
    localparam int RECIP3         = 21846;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AMOUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [AMT_BITS-1:0] AMOUNT_RST = 12'd256;
    localparam logic [FW_BITS-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [FH_BITS-1:0]  HEIGHT_RST = 13'd480;

    typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] t_pix;

    typedef struct packed {
        logic                    func;
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } t_in;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic                    frame_end;
    } t_out;

    typedef struct packed {
        t_pix                            centre;
        logic [NUM_CH-1:0][SUM_BITS-1:0] nsum;
        logic [CNT_BITS-1:0]             n;
        logic                            last;
    } t_job;
endpackage
`default_nettype wire

@@ rtl/shp_ram.sv @@
// ----------------------------------------------------------------------------
// shp_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module shp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/shp_queue.sv @@
// ----------------------------------------------------------------------------
// shp_queue
// Short job queue between the window front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none
module shp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire shp_pkg::t_job              i_job,
    input  wire logic                       i_pop,
    output shp_pkg::t_job                   o_job,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    shp_pkg::t_job          r_mem [DEPTH];
    logic [PW-1:0]          r_wptr, r_rptr;
    logic [$clog2(DEPTH+1)-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ($clog2(DEPTH+1))'(DEPTH));
    assign o_count = r_count;
endmodule
`default_nettype wire

@@ rtl/shp_front.sv @@
// ----------------------------------------------------------------------------
// shp_front
// Accepts transactions, runs the line stores and window, and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module shp_front #(
    parameter int MAX_WIDTH = shp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire shp_pkg::t_in                  i_data,
    input  wire logic [shp_pkg::FW_BITS-1:0]   i_fwidth,
    input  wire logic [shp_pkg::FH_BITS-1:0]   i_fheight,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output shp_pkg::t_job                      o_job
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RB = shp_pkg::ROW_BITS;
    localparam int PB = shp_pkg::NUM_CH * shp_pkg::CHANNEL_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RB-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [AW-1:0] r_idx;
    logic          r_emit;
    shp_pkg::t_pix r_newp;
    shp_pkg::t_pix r_w1, r_w2, r_w3, r_w4, r_w5, r_w7, r_w8;

    logic [CW-1:0] ew, col0, col1;
    logic [RB-1:0] eh, row0;
    logic [AW-1:0] idx;
    logic          emit, accept;
    shp_pkg::t_pix newp, rd_top, rd_mid;
    logic          up, down, left, right, last;

    always_comb begin
        if (32'(i_fwidth) > MAX_WIDTH) begin
            ew = CW'(MAX_WIDTH);
        end else if (i_fwidth < 11'd2) begin
            ew = CW'(2);
        end else begin
            ew = CW'(i_fwidth);
        end
        if (i_fheight < 13'd2) begin
            eh = RB'(2);
        end else if (32'(i_fheight) > shp_pkg::HEIGHT_LIMIT) begin
            eh = RB'(shp_pkg::HEIGHT_LIMIT);
        end else begin
            eh = i_fheight;
        end
    end

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !i_q_full;

    always_comb begin
        col0 = r_in_col;
        row0 = r_in_row;
        if (r_in_col >= ew) begin
            col0 = '0;
            if (r_in_row < RB'(shp_pkg::ROW_SAT)) begin
                row0 = r_in_row + 1'b1;
            end
        end
        if (!i_data.func && row0 < eh) begin
            newp = {i_data.blue_in, i_data.green_in, i_data.red_in};
        end else begin
            newp = '0;
        end
        idx  = (32'(col0) < MAX_WIDTH) ? AW'(col0) : AW'(MAX_WIDTH - 1);
        emit = (row0 >= RB'(2)) || (row0 == RB'(1) && col0 >= CW'(1));
        col1 = col0 + 1'b1;
    end

    always_comb begin
        up    = (r_out_row != '0);
        down  = ({1'b0, r_out_row} + 1'b1) < {1'b0, eh};
        left  = (r_out_col != '0);
        right = ({1'b0, r_out_col} + 1'b1) < {1'b0, ew};
        last  = !down && !right;
    end

    always_comb begin
        o_job.centre = r_w4;
        o_job.last   = last;
        o_job.n      = shp_pkg::CNT_BITS'(up) + shp_pkg::CNT_BITS'(down)
                     + shp_pkg::CNT_BITS'(left) + shp_pkg::CNT_BITS'(right);
        for (int k = 0; k < shp_pkg::NUM_CH; k++) begin
            o_job.nsum[k] = (up    ? shp_pkg::SUM_BITS'(r_w1[k]) : '0)
                          + (down  ? shp_pkg::SUM_BITS'(r_w7[k]) : '0)
                          + (left  ? shp_pkg::SUM_BITS'(r_w3[k]) : '0)
                          + (right ? shp_pkg::SUM_BITS'(r_w5[k]) : '0);
        end
    end

    assign o_push = (r_state == S_PUSH) && r_emit;

    always_comb begin
        n_state   = r_state;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD;
                    if (col1 >= ew) begin
                        n_in_col = '0;
                        n_in_row = (row0 < RB'(shp_pkg::ROW_SAT)) ? row0 + 1'b1 : row0;
                    end else begin
                        n_in_col = col1;
                        n_in_row = row0;
                    end
                end
            end
            S_RD: n_state = S_PUSH;
            S_PUSH: begin
                n_state = S_IDLE;
                if (r_emit) begin
                    if (last) begin
                        n_in_col  = '0;
                        n_in_row  = '0;
                        n_out_col = '0;
                        n_out_row = '0;
                    end else if ((r_out_col + 1'b1) >= ew) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_emit    <= 1'b0;
            r_w1 <= '0; r_w2 <= '0; r_w3 <= '0; r_w4 <= '0;
            r_w5 <= '0; r_w7 <= '0; r_w8 <= '0;
        end else begin
            r_state   <= n_state;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (accept) begin
                r_emit <= emit;
            end
            if (r_state == S_RD) begin
                r_w1 <= r_w2;
                r_w2 <= rd_top;
                r_w3 <= r_w4;
                r_w4 <= r_w5;
                r_w5 <= rd_mid;
                r_w7 <= r_w8;
                r_w8 <= r_newp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_newp <= newp;
            r_idx  <= idx;
        end
    end

    shp_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line_above (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (r_idx),
        .i_wdata (rd_mid),
        .i_raddr (idx),
        .o_rdata (rd_top)
    );

    shp_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (r_idx),
        .i_wdata (r_newp),
        .i_raddr (idx),
        .o_rdata (rd_mid)
    );
endmodule
`default_nettype wire

@@ rtl/shp_back.sv @@
// ----------------------------------------------------------------------------
// shp_back
// Weighted sum, rounding division and clamp for one queued job.
// ----------------------------------------------------------------------------
`default_nettype none
module shp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [shp_pkg::AMT_BITS-1:0]  i_amount,
    input  wire shp_pkg::t_job                 i_job,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output shp_pkg::t_out                      o_data
);
    localparam int NC = shp_pkg::NUM_CH;
    localparam int CB = shp_pkg::CHANNEL_BITS;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_SUM  = 2'd2;
    localparam logic [1:0] B_DIV  = 2'd3;

    logic [1:0]           r_state;
    shp_pkg::t_job        r_job;
    logic [NC-1:0][21:0]  r_pa;
    logic signed [23:0]   r_pb [NC];
    logic [NC-1:0][15:0]  r_t;
    logic [NC-1:0]        r_neg;
    logic                 r_valid;
    shp_pkg::t_out        r_out;

    logic [13:0]          na;
    logic signed [12:0]   am;
    logic signed [24:0]   num [NC];
    logic signed [24:0]   biased [NC];
    logic [NC-1:0][15:0]  tval;
    logic [NC-1:0]        negv;
    logic [NC-1:0][CB-1:0] q;
    logic [31:0]          prod [NC];
    logic [15:0]          qd [NC];

    assign o_pop = (r_state == B_IDLE) && !i_empty && !r_valid;

    always_comb begin
        case (r_job.n)
            3'd4:    na = {i_amount, 2'b00};
            3'd3:    na = {1'b0, i_amount, 1'b0} + {2'b00, i_amount};
            default: na = {1'b0, i_amount, 1'b0};
        endcase
        am = $signed({1'b0, i_amount}) - 13'sd256;
        for (int k = 0; k < NC; k++) begin
            num[k]  = $signed({3'b000, r_pa[k]}) - 25'(r_pb[k]);
            negv[k] = num[k][24] || (num[k] == '0);
            case (r_job.n)
                3'd4: begin
                    biased[k] = num[k] + 25'sd512;
                    tval[k]   = 16'(biased[k] >>> 10);
                end
                3'd3: begin
                    biased[k] = num[k] + 25'sd384;
                    tval[k]   = 16'(biased[k] >>> 8);
                end
                default: begin
                    biased[k] = num[k] + 25'sd256;
                    tval[k]   = 16'(biased[k] >>> 9);
                end
            endcase
            prod[k] = 32'(r_t[k]) * 32'(shp_pkg::RECIP3);
            qd[k]   = (r_job.n == 3'd3) ? prod[k][31:16] : r_t[k];
            if (r_neg[k]) begin
                q[k] = '0;
            end else if (qd[k] > 16'((1 << CB) - 1)) begin
                q[k] = '1;
            end else begin
                q[k] = CB'(qd[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL:  r_state <= B_SUM;
                B_SUM:  r_state <= B_DIV;
                B_DIV: begin
                    r_state <= B_IDLE;
                    r_valid <= 1'b1;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_MUL) begin
            for (int k = 0; k < NC; k++) begin
                r_pa[k] <= 22'(na) * 22'(r_job.centre[k]);
                r_pb[k] <= 24'(am) * 24'($signed({1'b0, r_job.nsum[k]}));
            end
        end
        if (r_state == B_SUM) begin
            r_t   <= tval;
            r_neg <= negv;
        end
        if (r_state == B_DIV) begin
            r_out.red_out   <= q[0];
            r_out.green_out <= q[1];
            r_out.blue_out  <= q[2];
            r_out.frame_end <= r_job.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;
endmodule
`default_nettype wire

@@ rtl/sharpen_3x3_pixel_filter.sv @@
// ----------------------------------------------------------------------------
// sharpen_3x3_pixel_filter
// Streaming 3x3 sharpen filter for RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_data): one pixel or flush tick per
// transaction. A frame is width*height pixels followed by width+1 flush
// ticks; the result for the last flush carries frame_end.
// Output channel (o_valid/i_ready, o_data): zero or one result per input
// transaction; the first width+1 transactions of a frame give none.
// The front end handles each transaction in order (line-store read, window
// shift and line-store write, job push) before it accepts the next. The back
// end handles each job in order (pop, multiply, subtract and round, divide
// and clamp) and pops the next only once its result is taken.
// A 4-entry job queue sits between the two; when the receiver stalls the
// output register holds, the queue fills and then o_ready drops.
// Configuration writes are taken at any clock where i_cfg_we is high and
// must be issued only while the block is idle.
// Reset (synchronous, active low) clears all counters, the window and the
// queue, and restores the register defaults; line stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sharpen_3x3_pixel_filter #(
    parameter int MAX_WIDTH   = shp_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = shp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire shp_pkg::t_in                       i_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output shp_pkg::t_out                           o_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [shp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [shp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    logic [shp_pkg::AMT_BITS-1:0] r_amount;
    logic [shp_pkg::FW_BITS-1:0]  r_fwidth;
    logic [shp_pkg::FH_BITS-1:0]  r_fheight;

    logic                             q_push, q_pop, q_empty, q_full;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    shp_pkg::t_job                    job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount  <= shp_pkg::AMOUNT_RST;
            r_fwidth  <= shp_pkg::WIDTH_RST;
            r_fheight <= shp_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                shp_pkg::CFG_AMOUNT: r_amount  <= i_cfg_data[shp_pkg::AMT_BITS-1:0];
                shp_pkg::CFG_WIDTH:  r_fwidth  <= i_cfg_data[shp_pkg::FW_BITS-1:0];
                shp_pkg::CFG_HEIGHT: r_fheight <= i_cfg_data[shp_pkg::FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    shp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_fwidth  (r_fwidth),
        .i_fheight (r_fheight),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_job     (job_in)
    );

    shp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    shp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_amount (r_amount),
        .i_job    (job_out),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    `SHP_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, q_push && q_full && !q_pop)
    `SHP_ASSERT_NEVER(a_q_underflow, i_clk, i_rst_n, q_pop && q_empty)
    `SHP_ASSERT_IMPLY(a_ready_space, i_clk, i_rst_n, o_ready, !q_full)
    `SHP_ASSERT_NEVER(a_q_count, i_clk, i_rst_n, q_count > ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
endmodule
`default_nettype wire
